[hdl/pwi_pkg.sv]
// Shared types, constants and helpers for the windowed-integral PID core.
// No dependencies; compiled first.
`default_nettype none
package pwi_pkg;

	localparam int PWI_HIST_DEPTH = 64;
	localparam int PWI_CFG_IDX_W  = 3;
	localparam int PWI_DIV_W      = 64;
	localparam int PWI_DIV_CNT_W  = 7;
	localparam int PWI_WRAP_BITS  = 33;

	typedef enum logic [PWI_CFG_IDX_W-1:0] {
		REG_SETPOINT,
		REG_PROP_GAIN,
		REG_INTEG_GAIN,
		REG_DERIV_GAIN,
		REG_CLAMP_LOW,
		REG_CLAMP_HIGH,
		REG_WRAP_MODE,
		REG_HISTORY_TIME
	} pwi_reg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLEAR, S_ERR, S_ERRCHK, S_WDIV, S_WFIX, S_PLMUL, S_PLACC,
		S_SCAN, S_APPEND, S_SUM, S_SUMFIN, S_TOTAL, S_PMUL, S_KMUL, S_IPMUL,
		S_DMUL, S_DSTART, S_DDIV, S_DFIX, S_COMBINE, S_DONE
	} pwi_state_t;

	typedef enum logic [4:0] {
		DP_NOP, DP_CLEAR, DP_ERR, DP_ERRCHK, DP_WFIX, DP_PLMUL, DP_PLACC,
		DP_SCAN, DP_APPEND, DP_SUM, DP_SUMFIN, DP_TOTAL, DP_PMUL, DP_KMUL,
		DP_IPMUL, DP_DMUL, DP_DSTART, DP_DFIX, DP_COMBINE, DP_OUT
	} pwi_op_t;

	typedef struct packed {
		pwi_op_t op;
		logic    load;
	} pwi_cmd_t;

	typedef struct packed {
		logic wrap_need;
		logic hist;
		logic dt_zero;
		logic div_busy;
		logic div_done;
		logic scan_done;
		logic sum_done;
	} pwi_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] r;
		if (v > 66'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = 32'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

[hdl/pwi_in_if.sv]
// Input channel: update or clear word with valid/ready.
// Standalone interface.
`default_nettype none
interface pwi_in_if;
	logic               valid;
	logic               ready;
	logic               operation;
	logic signed [31:0] measured;
	logic        [15:0] delta_time;
	modport source(output valid, operation, measured, delta_time, input ready);
	modport sink(input valid, operation, measured, delta_time, output ready);
endinterface
`default_nettype wire

[hdl/pwi_out_if.sv]
// Result channel: control output and its terms with valid/ready.
// Standalone interface.
`default_nettype none
interface pwi_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] control_out;
	logic signed [31:0] error_now;
	logic signed [31:0] error_total;
	logic signed [31:0] p_term;
	logic signed [31:0] i_term;
	logic signed [31:0] d_term;
	modport source(output valid, control_out, error_now, error_total, p_term, i_term,
		d_term, input ready);
	modport sink(input valid, control_out, error_now, error_total, p_term, i_term,
		d_term, output ready);
endinterface
`default_nettype wire

[hdl/pwi_cfg_if.sv]
// Register write channel: index and data with valid/ready.
// Uses pwi_pkg for the index width.
`default_nettype none
interface pwi_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [pwi_pkg::PWI_CFG_IDX_W-1:0]  index;
	logic [31:0]                        data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

[hdl/pwi_div.sv]
// Restoring divider, one quotient bit per cycle.
// Uses pwi_pkg.
`default_nettype none
module pwi_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [pwi_pkg::PWI_DIV_W-1:0]      dividend,
	input  logic [31:0]                        divisor,
	input  logic [pwi_pkg::PWI_DIV_CNT_W-1:0]  nbits,
	output logic                               busy,
	output logic                               done,
	output logic [pwi_pkg::PWI_DIV_W-1:0]      quotient,
	output logic [31:0]                        remainder
);
	import pwi_pkg::*;

	logic                     busy_q, done_q;
	logic [PWI_DIV_CNT_W-1:0] cnt_q;
	logic [PWI_DIV_W-1:0]     num_q;
	logic [31:0]              rem_q, dvs_q;
	logic [32:0]              rem_sh;
	logic                     ge;
	logic [32:0]              rem_sub;

	// dividend is left aligned; quotient bits shift in at the bottom
	assign rem_sh  = {rem_q, num_q[PWI_DIV_W-1]};
	assign ge      = rem_sh >= {1'b0, dvs_q};
	assign rem_sub = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= nbits;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == PWI_DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[PWI_DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
		end
	end

	assign busy      = busy_q;
	assign done      = done_q;
	assign quotient  = num_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[hdl/pwi_dpath.sv]
// Datapath: registers, shared multiplier, stamp memory, divider.
// Uses pwi_pkg and pwi_div; driven by pwi_ctrl commands.
`default_nettype none
module pwi_dpath #(
	parameter int HISTORY_DEPTH = pwi_pkg::PWI_HIST_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pwi_pkg::pwi_cmd_t                 cmd,
	output pwi_pkg::pwi_stat_t                st,
	input  logic                              cfg_valid,
	input  logic [pwi_pkg::PWI_CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                       cfg_data,
	input  logic signed [31:0]                measured,
	input  logic        [15:0]                delta_time,
	output logic signed [31:0]                control_out,
	output logic signed [31:0]                error_now,
	output logic signed [31:0]                error_total,
	output logic signed [31:0]                p_term,
	output logic signed [31:0]                i_term,
	output logic signed [31:0]                d_term
);
	import pwi_pkg::*;

	localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CW = $clog2(HISTORY_DEPTH + 1);

	function automatic logic [IW-1:0] ring(input logic [IW-1:0] b, input logic [CW-1:0] o);
		logic [CW:0] s;
		s = (CW+1)'(b) + (CW+1)'(o);
		if (s >= (CW+1)'(HISTORY_DEPTH)) s = s - (CW+1)'(HISTORY_DEPTH);
		return s[IW-1:0];
	endfunction

	// configuration
	logic signed [31:0] setpoint_q, prop_q, integ_q, deriv_q, low_q, high_q;
	logic               wrap_q;
	logic [30:0]        ht_q;

	// item and working registers
	logic signed [31:0] meas_q;
	logic [15:0]        dt_q;
	logic signed [32:0] err33_q;
	logic signed [31:0] err_q, last_q, accum_q, p_q, ip_q, d_q, c_q;
	logic               wlt_q, dneg_q;
	logic signed [65:0] mul_q;
	logic signed [32:0] mul_a, mul_b;
	logic signed [63:0] sum_q;
	logic [31:0]        prev_q;
	logic               rd_vld_s1, mul_vld_s2;
	logic [63:0]        rd_q;
	logic [63:0]        mem [HISTORY_DEPTH];
	logic [CW-1:0]      count_q, scan_i_q, kept_q, sj_q;
	logic [IW-1:0]      head_q;
	logic signed [31:0] o_c_q, o_err_q, o_tot_q, o_p_q, o_ip_q, o_d_q;

	// combinational
	logic signed [32:0] low33, high33, span33, err_cl33, wfix, r33, gap;
	logic signed [33:0] wdiv_arg;
	logic               bounded, wrapping, lt, gt, hist, dt_zero;
	logic signed [31:0] acc_cl, rd_err, dfix;
	logic [31:0]        rd_age, aged;
	logic [32:0]        a33;
	logic               keep, scan_issue, sum_issue, full, wr_en;
	logic [IW-1:0]      raddr, waddr, head_inc, app_head;
	logic [CW-1:0]      app_n;
	logic [63:0]        wdata, dmag, qneg;
	logic signed [65:0] mul_neg;
	logic               div_start, div_busy, div_done;
	logic [PWI_DIV_W-1:0]     div_dividend, div_quot;
	logic [31:0]              div_divisor, div_rem;
	logic [PWI_DIV_CNT_W-1:0] div_nbits;

	assign low33    = 33'(low_q);
	assign high33   = 33'(high_q);
	assign span33   = high33 - low33;
	assign bounded  = low_q != high_q;
	assign wrapping = bounded && wrap_q && (low_q < high_q);
	assign lt       = err33_q < low33;
	assign gt       = err33_q > high33;
	assign hist     = ht_q != '0;
	assign dt_zero  = dt_q == '0;
	assign err_cl33 = (err33_q < low33) ? low33 : ((err33_q < high33) ? err33_q : high33);
	assign acc_cl   = (accum_q < low_q) ? low_q : ((accum_q < high_q) ? accum_q : high_q);
	assign wdiv_arg = lt ? (34'(low33) - 34'(err33_q)) : (34'(err33_q) - 34'(high33));

	// wrapped error from the remainder of distance / span
	assign r33  = $signed({1'b0, div_rem});
	assign wfix = wlt_q ? ((div_rem == '0) ? low33 : (high33 - r33))
	                    : ((div_rem == '0) ? high33 : (low33 + r33));

	// stamp word: error in the upper half, age in the lower
	assign rd_err = $signed(rd_q[63:32]);
	assign rd_age = rd_q[31:0];
	assign a33    = {1'b0, rd_age} + 33'(dt_q);
	assign aged   = a33[32] ? '1 : a33[31:0];
	assign keep   = aged <= {1'b0, ht_q};
	assign gap    = $signed({1'b0, rd_age}) - $signed({1'b0, prev_q});

	assign scan_issue = (cmd.op == DP_SCAN) && (scan_i_q != count_q);
	assign sum_issue  = (cmd.op == DP_SUM) && (sj_q != '0);
	assign raddr      = scan_issue ? ring(head_q, scan_i_q) : ring(head_q, sj_q - 1'b1);
	assign head_inc   = (head_q == IW'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign full       = kept_q == CW'(HISTORY_DEPTH);
	assign app_head   = full ? head_inc : head_q;
	assign app_n      = full ? CW'(HISTORY_DEPTH - 1) : kept_q;
	assign wr_en      = ((cmd.op == DP_SCAN) && rd_vld_s1 && keep) || (cmd.op == DP_APPEND);
	assign waddr      = (cmd.op == DP_APPEND) ? ring(app_head, app_n) : ring(head_q, kept_q);
	assign wdata      = (cmd.op == DP_APPEND) ? {err_q, 32'b0} : {rd_err, aged};

	assign mul_neg = -mul_q;
	assign dmag    = mul_q[65] ? mul_neg[63:0] : mul_q[63:0];
	assign qneg    = -div_quot;
	always_comb begin
		if (dneg_q) begin
			dfix = (div_quot > 64'd2147483648) ? 32'sh80000000 : $signed(qneg[31:0]);
		end else begin
			dfix = (div_quot > 64'd2147483647) ? 32'sh7fffffff : $signed(div_quot[31:0]);
		end
	end

	assign div_start    = ((cmd.op == DP_ERRCHK) && wrapping && (lt || gt)) ||
	                      ((cmd.op == DP_DSTART) && !dt_zero);
	assign div_dividend = (cmd.op == DP_ERRCHK) ?
	                      {wdiv_arg[PWI_WRAP_BITS-1:0], (PWI_DIV_W-PWI_WRAP_BITS)'(0)} : dmag;
	assign div_divisor  = (cmd.op == DP_ERRCHK) ? span33[31:0] : {16'b0, dt_q};
	assign div_nbits    = (cmd.op == DP_ERRCHK) ? PWI_DIV_CNT_W'(PWI_WRAP_BITS)
	                                            : PWI_DIV_CNT_W'(PWI_DIV_W);

	pwi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.nbits     (div_nbits),
		.busy      (div_busy),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// shared multiplier operand select
	always_comb begin
		case (cmd.op)
			DP_PLMUL: begin
				mul_a = 33'(err_q);
				mul_b = $signed({17'b0, dt_q});
			end
			DP_PMUL: begin
				mul_a = 33'(prop_q);
				mul_b = 33'(err_q);
			end
			DP_KMUL: begin
				mul_a = 33'(integ_q);
				mul_b = $signed({17'b0, dt_q});
			end
			DP_IPMUL: begin
				mul_a = 33'($signed(mul_q[47:16]));
				mul_b = 33'(accum_q);
			end
			DP_DMUL: begin
				mul_a = 33'(deriv_q);
				mul_b = 33'(err_q) - 33'(last_q);
			end
			DP_SUM: begin
				mul_a = 33'(rd_err);
				mul_b = gap;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= '0;
			prop_q     <= '0;
			integ_q    <= '0;
			deriv_q    <= '0;
			low_q      <= '0;
			high_q     <= '0;
			wrap_q     <= 1'b0;
			ht_q       <= '0;
			last_q     <= '0;
			accum_q    <= '0;
			count_q    <= '0;
			head_q     <= '0;
			scan_i_q   <= '0;
			kept_q     <= '0;
			sj_q       <= '0;
			rd_vld_s1  <= 1'b0;
			mul_vld_s2 <= 1'b0;
		end else begin
			rd_vld_s1  <= scan_issue || sum_issue;
			mul_vld_s2 <= (cmd.op == DP_SUM) && rd_vld_s1;
			if (cfg_valid) begin
				case (cfg_index)
					REG_SETPOINT:     setpoint_q <= $signed(cfg_data);
					REG_PROP_GAIN:    prop_q     <= $signed(cfg_data);
					REG_INTEG_GAIN:   integ_q    <= $signed(cfg_data);
					REG_DERIV_GAIN:   deriv_q    <= $signed(cfg_data);
					REG_CLAMP_LOW:    low_q      <= $signed(cfg_data);
					REG_CLAMP_HIGH:   high_q     <= $signed(cfg_data);
					REG_WRAP_MODE:    wrap_q     <= cfg_data[0];
					REG_HISTORY_TIME: ht_q       <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (cmd.op)
				DP_CLEAR: begin
					accum_q <= '0;
					last_q  <= '0;
				end
				DP_ERR: begin
					scan_i_q <= '0;
					kept_q   <= '0;
				end
				DP_SCAN: begin
					if (scan_issue) scan_i_q <= scan_i_q + 1'b1;
					if (rd_vld_s1 && keep) kept_q <= kept_q + 1'b1;
				end
				DP_APPEND: begin
					head_q  <= app_head;
					count_q <= app_n + 1'b1;
					sj_q    <= app_n;
				end
				DP_SUM: begin
					if (sum_issue) sj_q <= sj_q - 1'b1;
				end
				DP_PLACC:   accum_q <= sat32(66'(accum_q) + (mul_q >>> 16));
				DP_SUMFIN:  accum_q <= sat32(66'(sum_q >>> 16));
				DP_TOTAL: begin
					if (bounded && !wrapping) accum_q <= acc_cl;
				end
				DP_COMBINE: last_q <= err_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			meas_q <= measured;
			dt_q   <= delta_time;
		end
		mul_q <= mul_a * mul_b;
		case (cmd.op)
			DP_CLEAR: begin
				err_q <= '0;
				p_q   <= '0;
				ip_q  <= '0;
				d_q   <= '0;
				c_q   <= '0;
			end
			DP_ERR:    err33_q <= 33'(setpoint_q) - 33'(meas_q);
			DP_ERRCHK: begin
				wlt_q <= lt;
				err_q <= sat32(66'(bounded ? err_cl33 : err33_q));
			end
			DP_WFIX:   err_q <= wfix[31:0];
			DP_APPEND: begin
				sum_q  <= '0;
				prev_q <= '0;
			end
			DP_SUM: begin
				if (rd_vld_s1) prev_q <= rd_age;
				if (mul_vld_s2) sum_q <= sum_q + 64'(mul_q);
			end
			DP_KMUL:   p_q  <= sat32(mul_q >>> 16);
			DP_DMUL:   ip_q <= sat32(mul_q >>> 16);
			DP_DSTART: begin
				dneg_q <= mul_q[65];
				if (dt_zero) d_q <= '0;
			end
			DP_DFIX:    d_q <= dfix;
			DP_COMBINE: c_q <= sat32(66'(p_q) + 66'(ip_q) + 66'(d_q));
			DP_OUT: begin
				o_c_q   <= c_q;
				o_err_q <= err_q;
				o_tot_q <= accum_q;
				o_p_q   <= p_q;
				o_ip_q  <= ip_q;
				o_d_q   <= d_q;
			end
			default: ;
		endcase
	end

	// stamp store, oldest entry at head_q
	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (scan_issue || sum_issue) rd_q <= mem[raddr];
	end

	assign st.wrap_need = wrapping && (lt || gt);
	assign st.hist      = hist;
	assign st.dt_zero   = dt_zero;
	assign st.div_busy  = div_busy;
	assign st.div_done  = div_done;
	assign st.scan_done = (scan_i_q == count_q) && !rd_vld_s1;
	assign st.sum_done  = (sj_q == '0) && !rd_vld_s1 && !mul_vld_s2;

	assign control_out = o_c_q;
	assign error_now   = o_err_q;
	assign error_total = o_tot_q;
	assign p_term      = o_p_q;
	assign i_term      = o_ip_q;
	assign d_term      = o_d_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(HISTORY_DEPTH))
		else $error("stamp count above depth");
	a_kept_le_scan: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= scan_i_q)
		else $error("compaction write passed read");
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= IW'(HISTORY_DEPTH - 1))
		else $error("head pointer out of range");

endmodule
`default_nettype wire

[hdl/pwi_ctrl.sv]
// Sequencer for one item: error, integral, terms, result word.
// Uses pwi_pkg; commands pwi_dpath.
`default_nettype none
module pwi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_operation,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output pwi_pkg::pwi_cmd_t  cmd,
	input  pwi_pkg::pwi_stat_t st
);
	import pwi_pkg::*;

	pwi_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE:    if (in_valid) state_nx = in_operation ? S_CLEAR : S_ERR;
			S_CLEAR:   state_nx = S_DONE;
			S_ERR:     state_nx = S_ERRCHK;
			S_ERRCHK:  state_nx = st.wrap_need ? S_WDIV : (st.hist ? S_SCAN : S_PLMUL);
			S_WDIV:    if (st.div_done) state_nx = S_WFIX;
			S_WFIX:    state_nx = st.hist ? S_SCAN : S_PLMUL;
			S_PLMUL:   state_nx = S_PLACC;
			S_PLACC:   state_nx = S_TOTAL;
			S_SCAN:    if (st.scan_done) state_nx = S_APPEND;
			S_APPEND:  state_nx = S_SUM;
			S_SUM:     if (st.sum_done) state_nx = S_SUMFIN;
			S_SUMFIN:  state_nx = S_TOTAL;
			S_TOTAL:   state_nx = S_PMUL;
			S_PMUL:    state_nx = S_KMUL;
			S_KMUL:    state_nx = S_IPMUL;
			S_IPMUL:   state_nx = S_DMUL;
			S_DMUL:    state_nx = S_DSTART;
			S_DSTART:  state_nx = st.dt_zero ? S_COMBINE : S_DDIV;
			S_DDIV:    if (st.div_done) state_nx = S_DFIX;
			S_DFIX:    state_nx = S_COMBINE;
			S_COMBINE: state_nx = S_DONE;
			S_DONE:    if (slot_free) state_nx = S_IDLE;
			default:   state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = (state_q == S_IDLE) && in_valid;
		case (state_q)
			S_CLEAR:   cmd.op = DP_CLEAR;
			S_ERR:     cmd.op = DP_ERR;
			S_ERRCHK:  cmd.op = DP_ERRCHK;
			S_WFIX:    cmd.op = DP_WFIX;
			S_PLMUL:   cmd.op = DP_PLMUL;
			S_PLACC:   cmd.op = DP_PLACC;
			S_SCAN:    cmd.op = DP_SCAN;
			S_APPEND:  cmd.op = DP_APPEND;
			S_SUM:     cmd.op = DP_SUM;
			S_SUMFIN:  cmd.op = DP_SUMFIN;
			S_TOTAL:   cmd.op = DP_TOTAL;
			S_PMUL:    cmd.op = DP_PMUL;
			S_KMUL:    cmd.op = DP_KMUL;
			S_IPMUL:   cmd.op = DP_IPMUL;
			S_DMUL:    cmd.op = DP_DMUL;
			S_DSTART:  cmd.op = DP_DSTART;
			S_DFIX:    cmd.op = DP_DFIX;
			S_COMBINE: cmd.op = DP_COMBINE;
			S_DONE:    cmd.op = slot_free ? DP_OUT : DP_NOP;
			default:   cmd.op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if ((state_q == S_DONE) && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_div_running: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WDIV || state_q == S_DDIV) |-> (st.div_busy || st.div_done))
		else $error("waiting on an idle divider");
	a_done_hands_off: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && slot_free) |=> (state_q == S_IDLE && out_valid_q))
		else $error("result word not posted");
	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("result word dropped");

endmodule
`default_nettype wire

[hdl/pid_controller_windowed_integral_core.sv]
// PID controller, Q16.16, with optional time-windowed integral over a stamp store.
// A clear zeroes the integral and terms; an update computes the error, wraps it by
// a divide when wrap mode needs it, integrates over the stamp window or plainly,
// and divides for the D term when dt != 0. One word in flight. Reset clears the
// configuration, integral, control state and stamp count; stamp contents and the
// result registers are left as they are.
`default_nettype none
module pid_controller_windowed_integral_core #(
	parameter int HISTORY_DEPTH = pwi_pkg::PWI_HIST_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	pwi_in_if.sink     req,
	pwi_out_if.source  rsp,
	pwi_cfg_if.sink    cfg
);
	import pwi_pkg::*;

	pwi_cmd_t  cmd;
	pwi_stat_t st;

	// register writes are always taken; the source must write only while no word is in flight (not enforced here)
	assign cfg.ready = 1'b1;

	// sequencer: walks one word through error, integral, P/I/D and the sum
	pwi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (req.valid),
		.in_operation (req.operation),
		.in_ready     (req.ready),
		.out_valid    (rsp.valid),
		.out_ready    (rsp.ready),
		.cmd          (cmd),
		.st           (st)
	);

	// datapath: shared 33x33 multiplier, divider, ring-buffer stamp memory,
	// and the result register that lets the next word enter while this one waits
	pwi_dpath #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.cfg_valid   (cfg.valid),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.measured    (req.measured),
		.delta_time  (req.delta_time),
		.control_out (rsp.control_out),
		.error_now   (rsp.error_now),
		.error_total (rsp.error_total),
		.p_term      (rsp.p_term),
		.i_term      (rsp.i_term),
		.d_term      (rsp.d_term)
	);

endmodule
`default_nettype wire
